@@ src/rlevd_pkg.sv @@
// ----------------------------------------------------------------------------
// rlevd_pkg
// Shared types, constants and helpers of the visibility row decoder.
// ----------------------------------------------------------------------------
package rlevd_pkg;

  localparam int unsigned LEAF_W     = 14;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RUN_SHIFT  = 3;
  localparam int unsigned RUN_W      = BYTE_W + RUN_SHIFT;
  localparam int unsigned BIT_IDX_W  = 3;
  localparam int unsigned MAX_LEAVES = 8192;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = QPTR_W + 1;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ADDR_W     = 3;

  localparam logic [LEAF_W-1:0] CNT_MAX    = {LEAF_W{1'b1}};
  localparam logic [LEAF_W-1:0] FIRST_LEAF = LEAF_W'(1);
  localparam logic [LEAF_W-1:0] LIMIT_MAX  = LEAF_W'(MAX_LEAVES);

  // register index as seen in the word address bit of paddr
  typedef enum logic [0:0] {
    REG_TOTAL_LEAVES = 1'b0
  } reg_idx_t;

  // one decoded item handed from the front to the back
  typedef struct packed {
    logic [LEAF_W-1:0] base;
    logic [BYTE_W-1:0] mask;
    logic              done;
  } job_t;

  function automatic logic [LEAF_W-1:0] sat_add(input logic [LEAF_W-1:0] a,
                                                input logic [RUN_W-1:0]  b);
    logic [LEAF_W:0] s;
    s = {1'b0, a} + (LEAF_W+1)'(b);
    return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[LEAF_W-1:0];
  endfunction

endpackage

@@ src/rlevd_front.sv @@
// ----------------------------------------------------------------------------
// rlevd_front
// Takes compressed bytes, tracks the row state and emits one job per item.
// ----------------------------------------------------------------------------
module rlevd_front import rlevd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] vis_byte,
  input  logic              row_start,
  input  logic [LEAF_W-1:0] total_leaves,
  output job_t              job
);

  logic [LEAF_W-1:0] cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              fin_r, fin_nxt;
  logic [LEAF_W-1:0] limit;
  logic [LEAF_W-1:0] cnt_s;
  logic              pend_s, fin_s;
  logic [BYTE_W-1:0] mask;

  assign limit = (total_leaves > LIMIT_MAX) ? LIMIT_MAX : total_leaves;

  always_comb begin
    cnt_s  = cnt_r;
    pend_s = pend_r;
    fin_s  = fin_r;
    mask   = '0;
    if (row_start) begin
      cnt_s  = FIRST_LEAF;
      pend_s = 1'b0;
      fin_s  = (FIRST_LEAF >= limit);
    end
    cnt_nxt  = cnt_s;
    pend_nxt = pend_s;
    fin_nxt  = fin_s;
    if (!fin_s) begin
      priority if (pend_s) begin
        cnt_nxt  = sat_add(cnt_s, {vis_byte, RUN_SHIFT'(0)});
        pend_nxt = 1'b0;
      end else if (vis_byte == '0) begin
        pend_nxt = 1'b1;
      end else begin
        mask    = vis_byte;
        cnt_nxt = sat_add(cnt_s, RUN_W'(BYTE_W));
      end
      fin_nxt = !pend_nxt && (cnt_nxt >= limit);
    end
  end

  assign job.base = cnt_s;
  assign job.mask = mask;
  assign job.done = fin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= FIRST_LEAF;
      pend_r <= 1'b0;
      fin_r  <= 1'b1;
    end else if (accept) begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

@@ src/rlevd_queue.sv @@
// ----------------------------------------------------------------------------
// rlevd_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module rlevd_queue import rlevd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_full,
  output logic q_empty
);

  job_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_job  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ src/rlevd_back.sv @@
// ----------------------------------------------------------------------------
// rlevd_back
// Expands jobs into registered results, one set bit per cycle unless stalled.
// ----------------------------------------------------------------------------
module rlevd_back import rlevd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [LEAF_W-1:0] leaf_index,
  output logic              has_leaf,
  output logic              row_done,
  output logic              last
);

  job_t              job_r, job_nxt;
  logic              job_v_r, job_v_nxt;
  logic              out_v_r, out_v_nxt;
  logic [LEAF_W-1:0] idx_r;
  logic              has_r, done_r, last_r;

  logic [BIT_IDX_W-1:0] lsb;
  logic [BYTE_W-1:0]    rest;
  logic                 take, emit, finish;

  // lowest set bit of the remaining mask
  always_comb begin
    lsb = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (job_r.mask[i]) begin
        lsb = BIT_IDX_W'(i);
      end
    end
  end

  assign rest   = job_r.mask & (job_r.mask - BYTE_W'(1));
  assign take   = !out_v_r || pop;
  assign emit   = take && job_v_r;
  assign finish = emit && (rest == '0);
  assign q_pop  = (!job_v_r || finish) && !q_empty;

  always_comb begin
    job_nxt   = job_r;
    job_v_nxt = job_v_r;
    if (q_pop) begin
      job_nxt   = q_job;
      job_v_nxt = 1'b1;
    end else if (finish) begin
      job_v_nxt = 1'b0;
    end else if (emit) begin
      job_nxt.mask = rest;
    end
    out_v_nxt = emit || (out_v_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (emit) begin
      has_r  <= (job_r.mask != '0);
      idx_r  <= (job_r.mask != '0) ? sat_add(job_r.base, RUN_W'(lsb)) : '0;
      done_r <= job_r.done;
      last_r <= (rest == '0);
    end
  end

  assign empty      = !out_v_r;
  assign leaf_index = idx_r;
  assign has_leaf   = has_r;
  assign row_done   = done_r;
  assign last       = last_r;

endmodule

@@ src/rle_visibility_row_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_visibility_row_decoder
// Zero-run-length visibility row decoder with queue-style ports.
// ----------------------------------------------------------------------------
// A compressed byte is taken whenever push is high and full is low. A zero byte,
// a run count or an ignored byte gives one result with has_leaf low; a nonzero
// byte gives one result per set bit, lowest bit first, with last on the final
// one. The result port hands out one result per cycle unless pop stalls it, so a
// byte yields one result per set bit, at least one; a four-entry job queue between
// front end and expander absorbs bursts. total_leaves sits at byte address 0 and
// is to be written only while idle by the user; the block does not enforce it.
module rle_visibility_row_decoder import rlevd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_vis_byte,
  input  logic              in_row_start,
  output logic              empty,
  input  logic              pop,
  output logic [LEAF_W-1:0] out_leaf_index,
  output logic              out_has_leaf,
  output logic              out_row_done,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEAF_W-1:0] total_leaves_r;
  logic              accept;
  logic              q_full, q_empty, q_pop;
  job_t              f_job, q_job;
  logic              reg_sel;

  assign reg_sel = (reg_idx_t'(paddr[ADDR_W-1]) == REG_TOTAL_LEAVES);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DATA_W'(total_leaves_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_leaves_r <= FIRST_LEAF;
    end else if (psel && penable && pwrite && reg_sel) begin
      total_leaves_r <= pwdata[LEAF_W-1:0];
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  rlevd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .vis_byte     (in_vis_byte),
    .row_start    (in_row_start),
    .total_leaves (total_leaves_r),
    .job          (f_job)
  );

  rlevd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_job  (f_job),
    .rd_en   (q_pop),
    .rd_job  (q_job),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  rlevd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .leaf_index (out_leaf_index),
    .has_leaf   (out_has_leaf),
    .row_done   (out_row_done),
    .last       (out_last)
  );

endmodule

@@ src/rlevd_checker.sv @@
// ----------------------------------------------------------------------------
// rlevd_checker
// Port-level checks on the visibility row decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlevd_checker import rlevd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              empty,
  input logic              pop,
  input logic [LEAF_W-1:0] out_leaf_index,
  input logic              out_has_leaf,
  input logic              out_last,
  input logic              pready
);

  // no leaf carried means a zero index
  a_no_leaf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_leaf) |-> (out_leaf_index == '0))
    else $error("leaf index nonzero without a leaf");

  // an item without leaves gives exactly one result
  a_no_leaf_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_has_leaf) |-> out_last)
    else $error("leafless result not marked last");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty)
    else $error("results visible after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_leaf_index) && $stable(out_last)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind rle_visibility_row_decoder rlevd_checker u_rlevd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .empty          (empty),
  .pop            (pop),
  .out_leaf_index (out_leaf_index),
  .out_has_leaf   (out_has_leaf),
  .out_last       (out_last),
  .pready         (pready)
);
